// ----- rtl/core/pfm_pkg.sv -----
// Shared types and constants for the pulse flow meter.
package pfm_pkg;

    localparam int ACC_W   = 100;  // serial operand and product / remainder width
    localparam int DVS_W   = 80;   // parallel operand (multiplicand or divisor) width
    localparam int STEP_W  = 7;
    localparam int WHOLE_W = 31;
    localparam int FRAC_W  = 20;
    localparam int CNT_W   = 64;
    localparam int TIME_W  = 48;
    localparam int UL_W    = 52;
    localparam int K_W     = 31;
    localparam int KIND_W  = 2;
    localparam int MS_W    = 16;
    localparam int ARM_W   = 32;

    localparam logic [KIND_W-1:0] KIND_PULSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ARM   = 2'd2;

    localparam logic [WHOLE_W-1:0] WHOLE_MAX  = 31'h7FFF_FFFF;
    localparam logic [FRAC_W-1:0]  FRAC_MAX   = 20'd999999;
    localparam logic [FRAC_W-1:0]  MICRO      = 20'd1000000;
    localparam logic [MS_W-1:0]    MS_PER_MIN = 16'd60000;
    localparam logic [K_W-1:0]     K_RESET    = 31'd450;

    localparam logic [STEP_W-1:0] STEPS_DIV   = 7'd100;
    localparam logic [STEP_W-1:0] STEPS_K     = 7'd31;
    localparam logic [STEP_W-1:0] STEPS_MIN   = 7'd16;
    localparam logic [STEP_W-1:0] STEPS_MICRO = 7'd20;

    typedef enum logic [1:0] {
        ALU_MUL = 2'b01,
        ALU_DIV = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic [STEP_W-1:0]   steps;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic ovf;   // quotient spilled above the whole-part width
    } alu_stat_t;

    typedef struct packed {
        logic           load;
        logic [K_W-1:0] delta;
    } arm_cmd_t;

endpackage

// ----- rtl/core/pfm_serial_alu.sv -----
// Bit-serial shift-add multiplier and restoring divider sharing one accumulator.
module pfm_serial_alu import pfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  alu_req_t            req,
    input  logic [DVS_W-1:0]    opa,
    input  logic [ACC_W-1:0]    opb,
    output alu_stat_t           stat,
    output logic [ACC_W-1:0]    acc,
    output logic [WHOLE_W-1:0]  quo
);

    alu_op_t             op_reg;
    logic [STEP_W-1:0]   count_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [DVS_W-1:0]    opa_reg;
    logic [ACC_W-1:0]    ser_reg;
    logic [WHOLE_W-1:0]  quo_reg;
    logic                ovf_reg;

    logic [ACC_W-1:0]    opa_ext;
    logic [ACC_W-1:0]    shifted;
    logic [ACC_W-1:0]    mul_sum;
    logic [ACC_W-1:0]    div_diff;
    logic                div_ge;

    assign opa_ext  = {{(ACC_W-DVS_W){1'b0}}, opa_reg};
    // multiplier bits and dividend bits both leave ser_reg MSB first
    assign shifted  = {acc_reg[ACC_W-2:0], ser_reg[ACC_W-1]};
    assign mul_sum  = {acc_reg[ACC_W-2:0], 1'b0} + (ser_reg[ACC_W-1] ? opa_ext : '0);
    assign div_ge   = shifted >= opa_ext;
    assign div_diff = shifted - opa_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= req.steps;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == {{(STEP_W-1){1'b0}}, 1'b1})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            opa_reg <= opa;
            ser_reg <= opb;
            acc_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            ser_reg <= {ser_reg[ACC_W-2:0], 1'b0};
            unique case (op_reg)
                ALU_MUL:
                begin
                    acc_reg <= mul_sum;
                end
                ALU_DIV:
                begin
                    acc_reg <= div_ge ? div_diff : shifted;
                    quo_reg <= {quo_reg[WHOLE_W-2:0], div_ge};
                    ovf_reg <= ovf_reg | quo_reg[WHOLE_W-1];
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign acc       = acc_reg;
    assign quo       = quo_reg;

endmodule

// ----- rtl/core/pfm_pulse_track.sv -----
// Pulse counter and armed-threshold tracking.
module pfm_pulse_track import pfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pulse,
    input  arm_cmd_t          arm,
    output logic [CNT_W-1:0]  pulse_count,
    output logic              hit
);

    logic [CNT_W-1:0] count_reg;
    logic [ARM_W-1:0] since_reg;   // low count bits minus the arming point
    logic [K_W-1:0]   delta_reg;
    logic [ARM_W-1:0] since_inc;

    assign since_inc = since_reg + 1'b1;
    assign hit = (delta_reg != '0) && (since_inc >= {1'b0, delta_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            since_reg <= '0;
            delta_reg <= '0;
        end
        else if (pulse)
        begin
            count_reg <= count_reg + 1'b1;
            since_reg <= since_inc;
            if (hit)
            begin
                delta_reg <= '0;
            end
        end
        else if (arm.load)
        begin
            since_reg <= '0;
            delta_reg <= arm.delta;
        end
    end

    assign pulse_count = count_reg;

endmodule

// ----- rtl/core/pulse_flow_meter.sv -----
// Pulse flow meter top level: handshake, sequencer and result register.
//
// Input words arrive on s_tvalid/s_tready with the item kind in s_tuser; results
// leave on m_tvalid/m_tready, one word per pulse, fetch or arm item (kind 3 is
// dropped without a result). pulses_per_litre is written through cfg_we/cfg_wdata.
// A pulse word is handled in the accept cycle and its result is registered the
// next cycle; with the sink ready, pulses are taken every cycle.
// Fetch and arm words run through one bit-serial multiply/divide unit, one bit
// per cycle (100 steps for a divide, 31/16/20 for the multiplies by K, 60000
// and 10^6). An arm runs a multiply and a divide; a fetch with no rate runs
// the volume passes only, and a fetch with a rate runs the rate passes too.
// No new word is taken while a fetch or arm is in the serial unit.
// The result register holds its word while m_tready is low; a new word is only
// accepted once that register is empty or being emptied in the same cycle.
// Reset clears the counters, the fetch history and the armed threshold, and
// sets pulses_per_litre to 450.
module pulse_flow_meter import pfm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [30:0]   cfg_wdata,     // pulses_per_litre
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,       // now_ms[47:0], threshold_microlitres[99:48]
    input  logic [1:0]    s_tuser,       // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata        // rate_whole[30:0], rate_millionths[50:31],
                                         // volume_whole[81:51], volume_millionths[101:82],
                                         // threshold_hit[102], status[103]
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_KDT   = 11'b000_0000_0010,
        ST_DP    = 11'b000_0000_0100,
        ST_RDIV1 = 11'b000_0000_1000,
        ST_RMUL  = 11'b000_0001_0000,
        ST_RDIV2 = 11'b000_0010_0000,
        ST_VDIV1 = 11'b000_0100_0000,
        ST_VMUL  = 11'b000_1000_0000,
        ST_VDIV2 = 11'b001_0000_0000,
        ST_AMUL  = 11'b010_0000_0000,
        ST_ADIV  = 11'b100_0000_0000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                launch_reg;
    logic [K_W-1:0]      k_reg;
    logic [CNT_W-1:0]    last_cnt_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic                m_valid_reg;

    logic [DVS_W-1:0]    dvs_reg;
    logic [ACC_W-1:0]    num_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [CNT_W-1:0]    dp_reg;
    logic [UL_W-1:0]     ul_reg;
    logic [WHOLE_W-1:0]  rate_whole_reg;
    logic [FRAC_W-1:0]   rate_frac_reg;
    logic [WHOLE_W-1:0]  vol_whole_reg;
    logic [FRAC_W-1:0]   vol_frac_reg;
    logic                hit_reg;
    logic                status_reg;

    logic                accept;
    logic                is_pulse;
    logic                is_fetch;
    logic                is_arm;
    logic [TIME_W-1:0]   now_ms;
    logic [UL_W-1:0]     threshold_ul;
    logic [CNT_W-1:0]    dp_now;
    logic [TIME_W-1:0]   dt_now;
    logic                need_rate;
    logic [K_W-1:0]      k_eff;
    logic                alu_done;
    logic                finish;

    alu_req_t            alu_req;
    alu_stat_t           alu_stat;
    logic [DVS_W-1:0]    alu_opa;
    logic [ACC_W-1:0]    alu_opb;
    logic [ACC_W-1:0]    alu_acc;
    logic [WHOLE_W-1:0]  alu_quo;

    arm_cmd_t            arm_cmd;
    logic [CNT_W-1:0]    pulse_count;
    logic                trk_hit;

    assign now_ms       = s_tdata[TIME_W-1:0];
    assign threshold_ul = s_tdata[TIME_W+UL_W-1:TIME_W];

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_pulse = accept && (s_tuser == KIND_PULSE);
    assign is_fetch = accept && (s_tuser == KIND_FETCH);
    assign is_arm   = accept && (s_tuser == KIND_ARM);

    assign dp_now    = pulse_count - last_cnt_reg;
    assign dt_now    = now_ms - last_time_reg;
    assign need_rate = (now_ms > last_time_reg) && (dp_now != '0);
    assign k_eff     = (k_reg == '0) ? {{(K_W-1){1'b0}}, 1'b1} : k_reg;
    assign alu_done  = alu_stat.done;

    // rate = dp*60000 / (K*dt): whole part by one divide, the remainder times 10^6
    // divided again gives the millionths; volume works the same on pulse_count / K
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_fetch)
                begin
                    state_next = need_rate ? ST_KDT : ST_VDIV1;
                end
                else if (is_arm)
                begin
                    state_next = ST_AMUL;
                end
            end
            ST_KDT:   if (alu_done) state_next = ST_DP;
            ST_DP:    if (alu_done) state_next = ST_RDIV1;
            ST_RDIV1: if (alu_done) state_next = alu_stat.ovf ? ST_VDIV1 : ST_RMUL;
            ST_RMUL:  if (alu_done) state_next = ST_RDIV2;
            ST_RDIV2: if (alu_done) state_next = ST_VDIV1;
            ST_VDIV1: if (alu_done) state_next = alu_stat.ovf ? ST_IDLE : ST_VMUL;
            ST_VMUL:  if (alu_done) state_next = ST_VDIV2;
            ST_VDIV2: if (alu_done) state_next = ST_IDLE;
            ST_AMUL:  if (alu_done) state_next = ST_ADIV;
            ST_ADIV:  if (alu_done) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign finish = alu_done && (state_next == ST_IDLE) && (state_reg != ST_IDLE);

    always_comb
    begin
        alu_req.start = launch_reg;
        alu_req.op    = ALU_MUL;
        alu_req.steps = STEPS_DIV;
        alu_opa       = '0;
        alu_opb       = '0;
        unique case (state_reg)
            ST_KDT:
            begin
                alu_req.steps = STEPS_K;
                alu_opa       = {{(DVS_W-TIME_W){1'b0}}, dt_reg};
                alu_opb       = {k_eff, {(ACC_W-K_W){1'b0}}};
            end
            ST_DP:
            begin
                alu_req.steps = STEPS_MIN;
                alu_opa       = {{(DVS_W-CNT_W){1'b0}}, dp_reg};
                alu_opb       = {MS_PER_MIN, {(ACC_W-MS_W){1'b0}}};
            end
            ST_RDIV1, ST_RDIV2:
            begin
                alu_req.op = ALU_DIV;
                alu_opa    = dvs_reg;
                alu_opb    = num_reg;
            end
            ST_RMUL, ST_VMUL:
            begin
                alu_req.steps = STEPS_MICRO;
                alu_opa       = num_reg[DVS_W-1:0];
                alu_opb       = {MICRO, {(ACC_W-FRAC_W){1'b0}}};
            end
            ST_VDIV1:
            begin
                alu_req.op = ALU_DIV;
                alu_opa    = {{(DVS_W-K_W){1'b0}}, k_eff};
                alu_opb    = {{(ACC_W-CNT_W){1'b0}}, pulse_count};
            end
            ST_VDIV2:
            begin
                alu_req.op = ALU_DIV;
                alu_opa    = {{(DVS_W-K_W){1'b0}}, k_eff};
                alu_opb    = num_reg;
            end
            ST_AMUL:
            begin
                // arming uses the raw register: a zero K gives a zero product, so a nonzero threshold arms at one pulse
                alu_req.steps = STEPS_K;
                alu_opa       = {{(DVS_W-UL_W){1'b0}}, ul_reg};
                alu_opb       = {k_reg, {(ACC_W-K_W){1'b0}}};
            end
            ST_ADIV:
            begin
                alu_req.op = ALU_DIV;
                alu_opa    = {{(DVS_W-FRAC_W){1'b0}}, MICRO};
                alu_opb    = num_reg;
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    assign arm_cmd.load  = alu_done && (state_reg == ST_ADIV) && !alu_stat.ovf;
    assign arm_cmd.delta = ((ul_reg != '0) && (alu_quo == '0)) ?
                           {{(K_W-1){1'b0}}, 1'b1} : alu_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            k_reg         <= K_RESET;
            last_cnt_reg  <= '0;
            last_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= (state_next != state_reg) && (state_next != ST_IDLE);
            if (cfg_we)
            begin
                k_reg <= cfg_wdata;
            end
            if (is_fetch)
            begin
                last_cnt_reg  <= pulse_count;
                last_time_reg <= now_ms;
            end
            if (is_pulse || finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_pulse || is_fetch || is_arm)
        begin
            rate_whole_reg <= '0;
            rate_frac_reg  <= '0;
            vol_whole_reg  <= '0;
            vol_frac_reg   <= '0;
            hit_reg        <= is_pulse && trk_hit;
            status_reg     <= 1'b0;
        end
        if (is_fetch)
        begin
            dt_reg <= dt_now;
            dp_reg <= dp_now;
        end
        if (is_arm)
        begin
            ul_reg <= threshold_ul;
        end
        if (alu_done)
        begin
            unique case (state_reg)
                ST_KDT:
                begin
                    dvs_reg <= alu_acc[DVS_W-1:0];
                end
                ST_DP, ST_RMUL, ST_VMUL, ST_AMUL:
                begin
                    num_reg <= alu_acc;
                end
                ST_RDIV1:
                begin
                    num_reg <= alu_acc;
                    if (alu_stat.ovf)
                    begin
                        rate_whole_reg <= WHOLE_MAX;
                        rate_frac_reg  <= FRAC_MAX;
                    end
                    else
                    begin
                        rate_whole_reg <= alu_quo;
                    end
                end
                ST_RDIV2:
                begin
                    rate_frac_reg <= alu_quo[FRAC_W-1:0];
                end
                ST_VDIV1:
                begin
                    num_reg <= alu_acc;
                    if (alu_stat.ovf)
                    begin
                        vol_whole_reg <= WHOLE_MAX;
                        vol_frac_reg  <= FRAC_MAX;
                    end
                    else
                    begin
                        vol_whole_reg <= alu_quo;
                    end
                end
                ST_VDIV2:
                begin
                    vol_frac_reg <= alu_quo[FRAC_W-1:0];
                end
                ST_ADIV:
                begin
                    status_reg <= alu_stat.ovf;
                end
                default:
                begin
                    status_reg <= status_reg;
                end
            endcase
        end
    end

    pfm_serial_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (alu_opa),
        .opb   (alu_opb),
        .stat  (alu_stat),
        .acc   (alu_acc),
        .quo   (alu_quo)
    );

    pfm_pulse_track u_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse       (is_pulse),
        .arm         (arm_cmd),
        .pulse_count (pulse_count),
        .hit         (trk_hit)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {status_reg, hit_reg, vol_frac_reg, vol_whole_reg,
                       rate_frac_reg, rate_whole_reg};

endmodule

// ----- tb/pulse_flow_meter_tb.sv -----
// Self-checking testbench for the pulse flow meter: directed and random words, scoreboarded.
module pulse_flow_meter_tb;
    import pfm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // dropped by the block
    localparam bit [127:0] MILLION    = 128'd1000000;
    localparam bit [127:0] RATE_SCALE = 128'd60000000000;  // ms per minute times 10^6
    localparam int SETTLE_CYCLES = 600;   // longer than the longest fetch
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  now_ms;
        logic [UL_W-1:0]    ul;
    } flow_word_t;

    typedef struct {
        logic [WHOLE_W-1:0] rate_whole;
        logic [FRAC_W-1:0]  rate_frac;
        logic [WHOLE_W-1:0] vol_whole;
        logic [FRAC_W-1:0]  vol_frac;
        logic               hit;
        logic               status;
    } meter_reading_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [30:0]    cfg_wdata = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [103:0]   s_tdata = '0;    // now_ms[47:0], threshold_microlitres[99:48]
    logic [1:0]     s_tuser = '0;    // kind
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [103:0]   m_tdata;         // rate_whole[30:0], rate_millionths[50:31],
                                     // volume_whole[81:51], volume_millionths[101:82],
                                     // threshold_hit[102], status[103]

    pulse_flow_meter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // meter state as the block should hold it
    bit [K_W-1:0]    k_factor = K_RESET;
    bit [CNT_W-1:0]  pulse_cnt;
    bit [CNT_W-1:0]  fetch_cnt;
    bit [TIME_W-1:0] fetch_time;
    bit [ARM_W-1:0]  arm_point;
    bit [K_W-1:0]    arm_delta;

    flow_word_t      pending_words[$];
    meter_reading_t  expected_readings[$];
    flow_word_t      cur_word;
    int              mismatches = 0;
    bit              quiet = 1'b0;
    bit              hold_req = 1'b0;
    int              send_gap = 0;
    int              stall_left = 0;
    int              hold_left = 0;
    bit [TIME_W-1:0] stim_time = '0;   // last fetch stamp in stimulus order
    int              words_made;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void split_scaled(input bit [127:0] v, output logic [WHOLE_W-1:0] whole,
                                         output logic [FRAC_W-1:0] frac);
        bit [127:0] q;
        bit [127:0] r;
        q = v / MILLION;
        r = v % MILLION;
        if (q > 128'(WHOLE_MAX)) begin
            whole = WHOLE_MAX;
            frac  = FRAC_MAX;
        end
        else begin
            whole = q[WHOLE_W-1:0];
            frac  = r[FRAC_W-1:0];
        end
    endfunction

    // returns 0 when the word produces no reading
    function automatic bit advance_meter(input flow_word_t w, output meter_reading_t rd);
        bit [127:0]       acc;
        bit [127:0]       kdiv;
        bit [CNT_W-1:0]   dp;
        bit [TIME_W-1:0]  dt;
        bit               forward;
        bit [ARM_W-1:0]   low;
        rd = '{default: '0};
        kdiv = (k_factor == 0) ? 128'd1 : 128'(k_factor);
        case (w.kind)
            KIND_PULSE: begin
                pulse_cnt = pulse_cnt + 1;
                low = pulse_cnt[ARM_W-1:0];
                if (arm_delta != 0 && (low - arm_point) >= {1'b0, arm_delta}) begin
                    rd.hit = 1'b1;
                    arm_delta = '0;
                end
            end
            KIND_FETCH: begin
                dp = pulse_cnt - fetch_cnt;
                forward = w.now_ms > fetch_time;
                dt = w.now_ms - fetch_time;
                fetch_cnt = pulse_cnt;
                fetch_time = w.now_ms;
                if (forward && dp != 0) begin
                    acc = 128'(dp) * RATE_SCALE;
                    acc = acc / kdiv;
                    acc = acc / 128'(dt);
                    split_scaled(acc, rd.rate_whole, rd.rate_frac);
                end
                acc = 128'(pulse_cnt) * MILLION / kdiv;
                split_scaled(acc, rd.vol_whole, rd.vol_frac);
            end
            KIND_ARM: begin
                acc = 128'(w.ul) * 128'(k_factor) / MILLION;
                if (acc > 128'(WHOLE_MAX))
                    rd.status = 1'b1;
                else begin
                    arm_point = pulse_cnt[ARM_W-1:0];
                    arm_delta = (w.ul != 0 && acc == 0) ? 31'd1 : acc[K_W-1:0];
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge clk) begin
        meter_reading_t rd;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                if (advance_meter(cur_word, rd))
                    expected_readings.push_back(rd);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cur_word.ul, cur_word.now_ms};
                    s_tuser  <= cur_word.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and scoreboard
    always @(posedge clk) begin
        meter_reading_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    mismatches++;
                end
                else begin
                    want = expected_readings.pop_front();
                    check_field("rate_whole", 64'(want.rate_whole), 64'(m_tdata[30:0]));
                    check_field("rate_millionths", 64'(want.rate_frac), 64'(m_tdata[50:31]));
                    check_field("volume_whole", 64'(want.vol_whole), 64'(m_tdata[81:51]));
                    check_field("volume_millionths", 64'(want.vol_frac),
                                64'(m_tdata[101:82]));
                    check_field("threshold_hit", 64'(want.hit), 64'(m_tdata[102]));
                    check_field("status", 64'(want.status), 64'(m_tdata[103]));
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic add_word(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now_ms,
                            input logic [UL_W-1:0] ul);
        flow_word_t w;
        w.kind = kind;
        w.now_ms = now_ms;
        w.ul = ul;
        pending_words.push_back(w);
        if (kind == KIND_FETCH)
            stim_time = now_ms;
    endtask

    task automatic write_k(input logic [K_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        k_factor = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all words to go in and all readings to come out, then let the serial unit settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_random(input int count);
        int sel;
        int run;
        int target;
        bit [63:0] ul;
        words_made = 0;
        while (words_made < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                run = $urandom_range(1, 6);
                repeat (run) add_word(KIND_PULSE, TIME_W'({$urandom, $urandom}),
                                      UL_W'({$urandom, $urandom}));
                words_made += run;
            end
            else if (sel < 72) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    add_word(KIND_FETCH, stim_time + $urandom_range(1, 5000),
                             UL_W'({$urandom, $urandom}));
                else if (sel == 7)
                    add_word(KIND_FETCH, stim_time, UL_W'({$urandom, $urandom}));
                else
                    add_word(KIND_FETCH, TIME_W'({$urandom, $urandom}),
                             UL_W'({$urandom, $urandom}));
                words_made++;
            end
            else if (sel < 92) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    // sized to trip after a handful of pulses
                    target = $urandom_range(1, 40);
                    if (k_factor == 0)
                        ul = 64'($urandom_range(1, 1000));
                    else
                        ul = (64'(target) * 64'd1000000 + k_factor - 1) / k_factor;
                end
                else if (sel == 6)
                    ul = '0;
                else if (sel == 7)
                    ul = 64'($urandom_range(1, 100000));
                else
                    ul = {$urandom, $urandom};
                add_word(KIND_ARM, TIME_W'({$urandom, $urandom}), ul[UL_W-1:0]);
                words_made++;
            end
            else
                add_word(KIND_NONE, TIME_W'({$urandom, $urandom}),
                         UL_W'({$urandom, $urandom}));
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset calibration
        add_word(KIND_FETCH, 48'd0, 52'd0);               // no time, no pulses
        repeat (3) add_word(KIND_PULSE, '0, '0);
        add_word(KIND_FETCH, 48'd1000, '0);
        add_word(KIND_ARM, '0, 52'd0);                    // disarm
        add_word(KIND_ARM, '0, 52'd1);                    // rounds to zero pulses, forced to 1
        add_word(KIND_PULSE, '0, '0);
        add_word(KIND_PULSE, '0, '0);
        add_word(KIND_ARM, '0, 52'd6667);                 // three pulses
        repeat (3) add_word(KIND_PULSE, '0, '0);
        add_word(KIND_NONE, '1, '1);
        add_word(KIND_FETCH, 48'd1000, '0);               // time equal
        add_word(KIND_FETCH, 48'd5, '0);                  // time backward
        add_word(KIND_ARM, '1, '1);                       // too large
        add_word(KIND_PULSE, '1, '1);
        add_word(KIND_FETCH, '1, '1);
        drain();

        // 1:1 pulses to microlitres puts the limit right at the arm boundary
        write_k(31'd1000000);
        add_word(KIND_ARM, '0, 52'h7FFF_FFFF);
        add_word(KIND_PULSE, '0, '0);
        add_word(KIND_ARM, '0, 52'h8000_0000);
        add_word(KIND_FETCH, stim_time + 48'd1, '0);
        drain();

        write_k(WHOLE_MAX);
        add_word(KIND_ARM, '0, 52'd1);
        add_word(KIND_ARM, '0, '1);
        add_word(KIND_FETCH, stim_time + 48'd1, '0);
        add_random(120);
        drain();

        write_k(31'd1);
        add_random(120);
        drain();

        write_k(K_RESET);
        add_random(60);
        @(negedge clk);
        hold_req = 1'b1;
        add_random(90);
        drain();

        write_k(K_W'($urandom_range(1, 32'h7FFF_FFFF)));
        add_random(150);
        drain();

        write_k(31'd7);
        add_random(150);
        drain();

        // zero calibration acts as one: short pulse run over a 1 ms window
        quiet = 1'b1;
        write_k(31'd0);
        add_word(KIND_FETCH, 48'd100, '0);
        repeat (40) add_word(KIND_PULSE, '0, '0);
        add_word(KIND_FETCH, 48'd101, '0);
        add_word(KIND_ARM, '0, 52'd5);
        add_word(KIND_FETCH, 48'd2000, '0);
        drain();

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
